[design/isws_pkg.sv]
// Shared types and codes for the indexed stack with search.
// Holds the request and status codes, the sequencer states and the field widths.
// No dependencies.
`default_nettype none

package isws_pkg;

  // Fixed field widths of the streaming payload.
  localparam int unsigned REQ_W   = 3;
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned STS_W   = 2;
  localparam int unsigned RDV_W   = 32;
  localparam int unsigned CNT_W   = 9;

  // Request codes.
  typedef enum logic [REQ_W-1:0] {
    REQ_GET   = 3'd0,
    REQ_SET   = 3'd1,
    REQ_PUSH  = 3'd2,
    REQ_POP   = 3'd3,
    REQ_CLEAR = 3'd4,
    REQ_FIND  = 3'd5
  } req_t;

  // Result status codes.
  typedef enum logic [STS_W-1:0] {
    STS_OK   = 2'd0,
    STS_MISS = 2'd1,
    STS_FULL = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_SCAN,
    S_DONE
  } state_t;

endpackage : isws_pkg

`default_nettype wire

[design/isws_ram.sv]
// Generic single-write, single-read memory with a registered read port.
// Used for the element store; depends on nothing.
`default_nettype none

module isws_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule : isws_ram

`default_nettype wire

[design/indexed_stack_with_search.sv]
// Indexed stack with linear search: one request in, one result out.
// Each request passes through a decode state and then a done state. A get or pop that
// reads an entry also passes through a read state, and a find on a non-empty store
// passes through a scan state, which compares one stored entry per cycle through the
// memory read port until the first match or the last stored entry. Set, push, clear
// and unknown requests, a get out of range and a pop or find on an empty store go
// straight from decode to done. A new request is taken only once the previous result
// is in the output register. Reset clears the count and the per-entry valid bits at
// once; an entry that is not valid reads as zero.
`default_nettype none

module indexed_stack_with_search
  import isws_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Request channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // slot[7:0], value[39:8]
  input  wire logic [2:0]  in_tuser,   // req_type[2:0]
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata   // status[1:0], read_value[33:2], found_slot[41:34],
                                       // count[50:42], is_empty[51], zero[55:52]
);

  localparam int unsigned AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned EXT = (ELEM_WIDTH > 32) ? ELEM_WIDTH : 32;

  // Sequencer and request registers.
  state_t                state_r, state_nxt;
  logic [REQ_W-1:0]      req_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [ELEM_WIDTH-1:0] val_r;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [DEPTH-1:0]      valid_r, valid_nxt;
  status_t               sts_r, sts_nxt;
  logic [RDV_W-1:0]      rdv_r, rdv_nxt;
  logic [SLOT_W-1:0]     fnd_r, fnd_nxt;

  // Output register.
  logic                  out_valid_r;
  logic [STS_W-1:0]      out_sts_r;
  logic [RDV_W-1:0]      out_rdv_r;
  logic [SLOT_W-1:0]     out_fnd_r;
  logic [CNT_W-1:0]      out_cnt_r;
  logic                  out_empty_r;

  // Memory port signals.
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [ELEM_WIDTH-1:0] rd_data;

  logic                  in_fire;
  logic                  out_free;
  logic [EXT-1:0]        val_ext;
  logic [ELEM_WIDTH-1:0] rd_elem;
  logic [EXT-1:0]        rd_ext;
  logic                  match;
  logic                  more;
  logic                  get_ok;
  logic [CNT_W-1:0]      slot_w;
  logic [CNT_W-1:0]      count_w;
  logic [CNT_W-1:0]      idx_inc;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  // Incoming value cut or extended to the element width.
  assign val_ext = EXT'(in_tdata[39:8]);

  // Element seen at the last read address; entries not written since reset or the last clear read as zero.
  assign rd_elem = valid_r[idx_r] ? rd_data : '0;
  assign rd_ext  = EXT'(rd_elem);
  assign match   = (rd_elem == val_r);

  // Comparisons in the common 9-bit width.
  assign slot_w  = CNT_W'(slot_r);
  assign count_w = CNT_W'(count_r);
  assign idx_inc = CNT_W'(idx_r) + CNT_W'(1);
  assign more    = (idx_inc < count_w);
  assign get_ok  = (slot_w < count_w);

  isws_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (val_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (req_r)
          REQ_GET:  state_nxt = get_ok ? S_READ : S_DONE;
          REQ_POP:  state_nxt = (count_r != '0) ? S_READ : S_DONE;
          REQ_FIND: state_nxt = (count_r != '0) ? S_SCAN : S_DONE;
          default:  state_nxt = S_DONE;
        endcase
      end
      S_READ: begin
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        if (match || !more) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Datapath and memory control for each state.
  always_comb begin
    count_nxt = count_r;
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    sts_nxt   = sts_r;
    rdv_nxt   = rdv_r;
    fnd_nxt   = fnd_r;
    wr_en     = 1'b0;
    wr_addr   = slot_r[AW-1:0];
    rd_en     = 1'b0;
    rd_addr   = idx_r;
    case (state_r)
      S_DECODE: begin
        sts_nxt = STS_OK;
        rdv_nxt = '0;
        fnd_nxt = '0;
        case (req_r)
          REQ_GET: begin
            if (get_ok) begin
              rd_en   = 1'b1;
              rd_addr = slot_r[AW-1:0];
              idx_nxt = slot_r[AW-1:0];
            end else begin
              sts_nxt = STS_MISS;
            end
          end
          REQ_SET: begin
            if (slot_w >= CNT_W'(DEPTH)) begin
              sts_nxt = STS_FULL;
            end else begin
              wr_en   = 1'b1;
              wr_addr = slot_r[AW-1:0];
              valid_nxt[slot_r[AW-1:0]] = 1'b1;
              if (count_w < slot_w + CNT_W'(1)) begin
                count_nxt = CW'(slot_w + CNT_W'(1));
              end
            end
          end
          REQ_PUSH: begin
            if (count_w >= CNT_W'(DEPTH)) begin
              sts_nxt = STS_FULL;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = count_r[AW-1:0];
              valid_nxt[count_r[AW-1:0]] = 1'b1;
              count_nxt = count_r + CW'(1);
            end
          end
          REQ_POP: begin
            if (count_r == '0) begin
              sts_nxt = STS_MISS;
            end else begin
              count_nxt = count_r - CW'(1);
              rd_en     = 1'b1;
              rd_addr   = count_nxt[AW-1:0];
              idx_nxt   = count_nxt[AW-1:0];
            end
          end
          REQ_CLEAR: begin
            valid_nxt = '0;
            count_nxt = '0;
          end
          REQ_FIND: begin
            sts_nxt = STS_MISS;
            if (count_r != '0) begin
              rd_en   = 1'b1;
              rd_addr = '0;
              idx_nxt = '0;
            end
          end
          default: begin
            sts_nxt = STS_MISS;
          end
        endcase
      end
      S_READ: begin
        rdv_nxt = rd_ext[RDV_W-1:0];
      end
      S_SCAN: begin
        if (match) begin
          sts_nxt = STS_OK;
          fnd_nxt = SLOT_W'(idx_r);
        end else if (more) begin
          // Fetch the next entry; its data arrives in the following cycle.
          rd_en   = 1'b1;
          rd_addr = AW'(idx_inc);
          idx_nxt = AW'(idx_inc);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r  <= in_tuser;
      slot_r <= in_tdata[7:0];
      val_r  <= val_ext[ELEM_WIDTH-1:0];
    end
    idx_r <= idx_nxt;
    sts_r <= sts_nxt;
    rdv_r <= rdv_nxt;
    fnd_r <= fnd_nxt;
    if (state_r == S_DONE && out_free) begin
      out_sts_r   <= sts_r;
      out_rdv_r   <= rdv_r;
      out_fnd_r   <= fnd_r;
      out_cnt_r   <= count_w;
      out_empty_r <= (count_r == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_empty_r, out_cnt_r, out_fnd_r, out_rdv_r, out_sts_r};

endmodule : indexed_stack_with_search

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the indexed stack with search.
// Drives request transfers from a queue, predicts every result with a shadow copy
// of the store, and compares each result transfer field by field. Needs isws_pkg.
`timescale 1ns / 1ps

module tb_top;
  import isws_pkg::*;

  localparam int STACK_DEPTH = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int REPORT_LIMIT = 10;
  localparam int PHASE_ITEMS = 137;

  // Request codes that the block does not know.
  localparam logic [REQ_W-1:0] REQ_BAD_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_BAD_HI = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0]   kind;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] value;
  } stack_req_t;

  typedef struct {
    status_t            status;
    logic [RDV_W-1:0]   read_value;
    logic [SLOT_W-1:0]  found_slot;
    logic [CNT_W-1:0]   count;
    logic               is_empty;
  } stack_resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;

  // Shadow copy of the element store and its length.
  logic [VALUE_W-1:0] shadow_mem [STACK_DEPTH];
  int                 shadow_len = 0;

  stack_req_t  request_q [$];
  stack_resp_t pending_results [$];

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_ask = 1'b0;
  int   hold_left = 0;
  bit   in_taken = 1'b0;
  int   err_cnt = 0;

  indexed_stack_with_search #(
    .DEPTH      (STACK_DEPTH),
    .ELEM_WIDTH (VALUE_W)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Applies one request to the shadow store and returns the result it causes.
  function automatic stack_resp_t stack_apply(stack_req_t r);
    stack_resp_t res;
    int pos;
    int i;
    pos = int'(r.slot);
    res.status = STS_OK;
    res.read_value = '0;
    res.found_slot = '0;
    case (r.kind)
      REQ_GET: begin
        if (pos < shadow_len) res.read_value = shadow_mem[pos];
        else res.status = STS_MISS;
      end
      REQ_SET: begin
        if (pos >= STACK_DEPTH) begin
          res.status = STS_FULL;
        end else begin
          shadow_mem[pos] = r.value;
          if (shadow_len < pos + 1) shadow_len = pos + 1;
        end
      end
      REQ_PUSH: begin
        if (shadow_len >= STACK_DEPTH) begin
          res.status = STS_FULL;
        end else begin
          shadow_mem[shadow_len] = r.value;
          shadow_len++;
        end
      end
      REQ_POP: begin
        if (shadow_len == 0) begin
          res.status = STS_MISS;
        end else begin
          shadow_len--;
          res.read_value = shadow_mem[shadow_len];
        end
      end
      REQ_CLEAR: begin
        for (i = 0; i < STACK_DEPTH; i++) shadow_mem[i] = '0;
        shadow_len = 0;
      end
      REQ_FIND: begin
        // Only the lowest matching position counts.
        res.status = STS_MISS;
        for (i = 0; i < shadow_len; i++) begin
          if (res.status == STS_MISS && shadow_mem[i] == r.value) begin
            res.status = STS_OK;
            res.found_slot = i[SLOT_W-1:0];
          end
        end
      end
      default: res.status = STS_MISS;
    endcase
    res.count = shadow_len[CNT_W-1:0];
    res.is_empty = (shadow_len == 0);
    return res;
  endfunction

  function automatic stack_req_t make_req(logic [REQ_W-1:0] kind, logic [SLOT_W-1:0] slot,
                                          logic [VALUE_W-1:0] value);
    stack_req_t r;
    r.kind = kind;
    r.slot = slot;
    r.value = value;
    return r;
  endfunction

  // Mostly well-formed traffic over a small value pool so that finds hit,
  // with the odd wide slot, full-range value, clear or unknown code.
  function automatic stack_req_t rand_request();
    stack_req_t r;
    int pick;
    int vsel;
    pick = $urandom_range(0, 99);
    vsel = $urandom_range(0, 9);
    if (pick < 25)      r.kind = REQ_PUSH;
    else if (pick < 48) r.kind = REQ_POP;
    else if (pick < 62) r.kind = REQ_SET;
    else if (pick < 78) r.kind = REQ_GET;
    else if (pick < 94) r.kind = REQ_FIND;
    else if (pick < 97) r.kind = REQ_CLEAR;
    else r.kind = ($urandom_range(0, 1) == 0) ? REQ_BAD_LO : REQ_BAD_HI;
    if ($urandom_range(0, 4) == 0) r.slot = SLOT_W'($urandom_range(0, 255));
    else r.slot = SLOT_W'($urandom_range(0, STACK_DEPTH + 3));
    if (vsel < 6)       r.value = 32'h5A5A_0000 | $urandom_range(0, 5);
    else if (vsel == 6) r.value = '0;
    else if (vsel == 7) r.value = '1;
    else r.value = $urandom;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    err_cnt++;
    if (err_cnt <= REPORT_LIMIT)
      $display("%0t: mismatch on %0s: expected %h, got %h", $time, what, want, got);
  endtask

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) report_mismatch(what, want, got);
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || in_tvalid || pending_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic load_random(int n);
    for (int k = 0; k < n; k++) request_q.push_back(rand_request());
  endtask

  // Request driver: holds an offered transfer until it is taken.
  always @(negedge clk) begin
    stack_req_t item;
    if (!(in_tvalid && !in_taken)) begin
      in_taken = 1'b0;
      if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        item = request_q.pop_front();
        in_tdata <= {item.value, item.slot};
        in_tuser <= item.kind;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    logic rdy;
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (hold_ask) begin
      hold_ask = 1'b0;
      hold_left = HOLD_CYCLES;
      rdy = 1'b0;
    end else begin
      rdy = ($urandom_range(0, 99) >= recv_stall_pct);
    end
    out_tready <= rdy;
  end

  // Monitor: predicts on each request transfer, checks each result transfer.
  always @(posedge clk) begin
    stack_req_t  req;
    stack_resp_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        in_taken = 1'b1;
        req.kind = in_tuser;
        req.slot = in_tdata[7:0];
        req.value = in_tdata[39:8];
        pending_results.push_back(stack_apply(req));
      end
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", '0, out_tdata[31:0]);
        end else begin
          want = pending_results.pop_front();
          check_field("status", 32'(want.status), 32'(out_tdata[1:0]));
          check_field("read_value", want.read_value, out_tdata[33:2]);
          check_field("found_slot", 32'(want.found_slot), 32'(out_tdata[41:34]));
          check_field("count", 32'(want.count), 32'(out_tdata[50:42]));
          check_field("is_empty", 32'(want.is_empty), 32'(out_tdata[51]));
        end
      end
    end
  end

  // Test sequence.
  initial begin
    for (int i = 0; i < STACK_DEPTH; i++) shadow_mem[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    @(posedge clk);

    // Directed part: empty store, extremes, stale entries after pop, full store.
    request_q.push_back(make_req(REQ_GET, 8'd0, 32'h0));
    request_q.push_back(make_req(REQ_POP, 8'd0, 32'h0));
    request_q.push_back(make_req(REQ_FIND, 8'd0, 32'h0));
    request_q.push_back(make_req(REQ_PUSH, 8'd0, 32'h0000_0000));
    request_q.push_back(make_req(REQ_PUSH, 8'd0, 32'hFFFF_FFFF));
    request_q.push_back(make_req(REQ_FIND, 8'd0, 32'hFFFF_FFFF));
    request_q.push_back(make_req(REQ_FIND, 8'd0, 32'h0000_0000));
    request_q.push_back(make_req(REQ_POP, 8'd0, 32'h0));
    request_q.push_back(make_req(REQ_SET, 8'd3, 32'hA5A5_A5A5));
    request_q.push_back(make_req(REQ_GET, 8'd1, 32'h0));
    request_q.push_back(make_req(REQ_GET, 8'd2, 32'h0));
    request_q.push_back(make_req(REQ_GET, 8'd4, 32'h0));
    request_q.push_back(make_req(REQ_SET, 8'd255, 32'h1234_5678));
    request_q.push_back(make_req(REQ_SET, 8'd16, 32'h1234_5678));
    request_q.push_back(make_req(REQ_SET, 8'd15, 32'h5A5A_5A5A));
    request_q.push_back(make_req(REQ_PUSH, 8'd0, 32'h1111_1111));
    request_q.push_back(make_req(REQ_GET, 8'd255, 32'hFFFF_FFFF));
    request_q.push_back(make_req(REQ_FIND, 8'd0, 32'h1234_5678));
    request_q.push_back(make_req(REQ_BAD_LO, 8'd255, 32'hFFFF_FFFF));
    request_q.push_back(make_req(REQ_BAD_HI, 8'd0, 32'h0));
    request_q.push_back(make_req(REQ_CLEAR, 8'd0, 32'h0));
    request_q.push_back(make_req(REQ_SET, 8'd2, 32'h0000_0001));
    request_q.push_back(make_req(REQ_GET, 8'd1, 32'h0));
    request_q.push_back(make_req(REQ_POP, 8'd0, 32'h0));
    request_q.push_back(make_req(REQ_CLEAR, 8'd0, 32'h0));
    wait_drained();

    // No idling, with one long receiver hold-off so the input backs up.
    hold_ask = 1'b1;
    load_random(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 52;
    recv_stall_pct = 0;
    load_random(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 52;
    load_random(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 28;
    recv_stall_pct = 28;
    load_random(PHASE_ITEMS);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
